>>> src/scdc_pkg.sv
package scdc_pkg;

   // Frame header and terminator bytes
   localparam logic [7:0] SYNC_BYTE  = 8'd45;
   localparam logic [7:0] ID_MOVE    = 8'd230;
   localparam logic [7:0] ID_VEL     = 8'd232;
   localparam logic [7:0] ID_FOLLOW  = 8'd233;
   localparam logic [7:0] NEWLINE    = 8'h0A;
   localparam int         FOLLOW_LEN = 4;

   // Register indexes on the csr port
   localparam logic [2:0] REG_MIN_AUTO_PWM     = 3'd0;
   localparam logic [2:0] REG_MAX_AUTO_PWM     = 3'd1;
   localparam logic [2:0] REG_STREAM_TIMEOUT   = 3'd2;
   localparam logic [2:0] REG_SPIN_PWM         = 3'd3;
   localparam logic [2:0] REG_LINEAR_DEADBAND  = 3'd4;
   localparam logic [2:0] REG_ANGULAR_DEADBAND = 3'd5;

   // Reset values of the registers
   localparam logic [7:0]  RST_MIN_AUTO_PWM     = 8'd40;
   localparam logic [7:0]  RST_MAX_AUTO_PWM     = 8'd60;
   localparam logic [15:0] RST_STREAM_TIMEOUT   = 16'd100;
   localparam logic [7:0]  RST_SPIN_PWM         = 8'd50;
   localparam logic [15:0] RST_LINEAR_DEADBAND  = 16'd655;
   localparam logic [15:0] RST_ANGULAR_DEADBAND = 16'd6554;

   // Only bytes 0..9 of a frame are ever decoded
   localparam int FIELD_BYTES = 10;

   localparam int RSP_BITS = 24;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_BYTE,
      KIND_EOF
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic [7:0]    data;
   } item_type;

   typedef struct packed {
      logic [7:0]  min_auto_pwm;
      logic [7:0]  max_auto_pwm;
      logic [15:0] stream_timeout_ms;
      logic [7:0]  spin_pwm;
      logic [15:0] linear_deadband;
      logic [15:0] angular_deadband;
   } cfg_type;

endpackage

>>> src/scdc_front.sv
module scdc_front #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tuser,
   output scdc_pkg::item_type item,
   output logic               item_valid,
   input  logic               item_pop
);
   import scdc_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   item_type         queue_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   item_type         incoming;
   logic             push, pop;

   // classify the incoming word
   always_comb begin
      incoming.data = req_tdata;
      if (req_tuser) begin
         incoming.kind = KIND_TICK;
      end else if (req_tdata == NEWLINE) begin
         incoming.kind = KIND_EOF;
      end else begin
         incoming.kind = KIND_BYTE;
      end
   end

   assign req_tready = (count_ff != CW'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = item_pop && item_valid;

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

>>> src/scdc_back.sv
module scdc_back #(
   parameter int FRAME_DEPTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  scdc_pkg::cfg_type               cfg,
   input  scdc_pkg::item_type              item,
   input  logic                            item_valid,
   output logic                            item_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [scdc_pkg::RSP_BITS-1:0]   rsp_tdata
);
   import scdc_pkg::*;

   localparam int LW = $clog2(FRAME_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_FETCH,
      ST_CONV,
      ST_MUL,
      ST_APPLY,
      ST_SEND
   } state_type;

   // IEEE single to Q16.16 as {sign, magnitude}, truncated, saturated
   function automatic logic [32:0] to_q16(input logic [31:0] bits);
      logic [7:0]  e;
      logic [22:0] m;
      logic        neg;
      logic [23:0] sig;
      logic [7:0]  ee;
      logic [7:0]  k;
      logic [31:0] lim;
      logic [31:0] wide;
      logic [31:0] mag;
      e    = bits[30:23];
      m    = bits[22:0];
      neg  = bits[31];
      lim  = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      sig  = (e == 8'd0) ? {1'b0, m} : {1'b1, m};
      ee   = (e == 8'd0) ? 8'd1 : e;
      k    = 8'd0;
      wide = 32'd0;
      mag  = 32'd0;
      if (e == 8'hFF) begin
         mag = (m != 23'd0) ? 32'd0 : lim;
      end else if (ee >= 8'd134) begin
         k = ee - 8'd134;
         if (k >= 8'd8) begin
            mag = lim;
         end else begin
            wide = {8'd0, sig} << k[2:0];
            mag  = (wide > lim) ? lim : wide;
         end
      end else begin
         k = 8'd134 - ee;
         mag = (k >= 8'd32) ? 32'd0 : ({8'd0, sig} >> k[4:0]);
      end
      return {neg, mag};
   endfunction

   // IEEE single to whole ms, rounded up, saturated
   function automatic logic [31:0] to_ms(input logic [31:0] bits);
      logic [7:0]  e;
      logic [22:0] m;
      logic [23:0] sig;
      logic [7:0]  ee;
      logic [7:0]  k;
      logic [31:0] q;
      logic [31:0] rem;
      logic [31:0] r;
      e   = bits[30:23];
      m   = bits[22:0];
      sig = (e == 8'd0) ? {1'b0, m} : {1'b1, m};
      ee  = (e == 8'd0) ? 8'd1 : e;
      k   = 8'd0;
      q   = 32'd0;
      rem = 32'd0;
      r   = 32'd0;
      if (bits[31]) begin
         r = 32'd0;
      end else if (e == 8'hFF) begin
         r = (m != 23'd0) ? 32'd0 : 32'hFFFF_FFFF;
      end else if (e == 8'd0 && m == 23'd0) begin
         r = 32'd0;
      end else if (ee >= 8'd150) begin
         k = ee - 8'd150;
         r = (k >= 8'd9) ? 32'hFFFF_FFFF : ({8'd0, sig} << k[3:0]);
      end else begin
         k = 8'd150 - ee;
         if (k >= 8'd32) begin
            r = 32'd1;
         end else begin
            q   = {8'd0, sig} >> k[4:0];
            rem = {8'd0, sig} & ~(32'hFFFF_FFFF << k[4:0]);
            r   = q + {31'd0, (rem != 32'd0)};
         end
      end
      return r;
   endfunction

   state_type         state_ff, state_in;
   logic [7:0]        frame_ff [FIELD_BYTES];
   logic [7:0]        frame_in [FIELD_BYTES];
   logic [LW-1:0]     len_ff, len_in;
   logic              follow_ff, follow_in;
   logic              rotate_ff, rotate_in;
   logic              dir_ff, dir_in;
   logic [7:0]        move_pwm_ff, move_pwm_in;
   logic [31:0]       duration_ff, duration_in;
   logic [31:0]       move_el_ff, move_el_in;
   logic [31:0]       stream_el_ff, stream_el_in;
   logic [7:0]        left_ff, left_in;
   logic [7:0]        right_ff, right_in;
   logic [31:0]       lin_mag_ff, lin_mag_in;
   logic              lin_neg_ff, lin_neg_in;
   logic [31:0]       ang_mag_ff, ang_mag_in;
   logic              ang_neg_ff, ang_neg_in;
   logic [31:0]       ms_ff, ms_in;
   logic signed [41:0] prod_ff, prod_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic signed [8:0]  diff;
   logic signed [42:0] num;
   logic [7:0]         auto_pwm;
   logic [31:0]        ldb, adb;
   logic               ang_pos, ang_negv, new_dir;
   logic [7:0]         pwm_eff, sr, sl;
   logic               dl;
   logic [32:0]        lin_q, ang_q;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign item_pop   = (state_ff == ST_FETCH) && item_valid;

   assign diff = $signed({1'b0, cfg.max_auto_pwm}) - $signed({1'b0, cfg.min_auto_pwm});
   assign num  = $signed({prod_ff[41], prod_ff}) + $signed({19'd0, cfg.min_auto_pwm, 16'd0});
   assign ldb  = {16'd0, cfg.linear_deadband};
   assign adb  = {16'd0, cfg.angular_deadband};
   assign lin_q = to_q16({frame_ff[5], frame_ff[4], frame_ff[3], frame_ff[2]});
   assign ang_q = to_q16({frame_ff[9], frame_ff[8], frame_ff[7], frame_ff[6]});

   // follow pwm: saturate to 0..255
   always_comb begin
      if (num <= 43'sd0) begin
         auto_pwm = 8'd0;
      end else if (|num[42:24]) begin
         auto_pwm = 8'hFF;
      end else begin
         auto_pwm = num[23:16];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      frame_in     = frame_ff;
      len_in       = len_ff;
      follow_in    = follow_ff;
      rotate_in    = rotate_ff;
      dir_in       = dir_ff;
      move_pwm_in  = move_pwm_ff;
      duration_in  = duration_ff;
      move_el_in   = move_el_ff;
      stream_el_in = stream_el_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      lin_mag_in   = lin_mag_ff;
      lin_neg_in   = lin_neg_ff;
      ang_mag_in   = ang_mag_ff;
      ang_neg_in   = ang_neg_ff;
      ms_in        = ms_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      ang_pos      = !ang_neg_ff && (ang_mag_ff > adb);
      ang_negv     = ang_neg_ff && (ang_mag_ff > adb);
      new_dir      = lin_neg_ff;
      pwm_eff      = move_pwm_ff;
      sr           = 8'd0;
      sl           = 8'd0;
      dl           = 1'b0;

      case (state_ff)
         ST_FETCH: begin
            if (item_valid) begin
               if (item.kind == KIND_TICK) begin
                  if (move_el_ff != 32'hFFFF_FFFF) move_el_in = move_el_ff + 32'd1;
                  if (stream_el_ff != 32'hFFFF_FFFF) stream_el_in = stream_el_ff + 32'd1;
                  state_in = ST_SEND;
               end else begin
                  if (len_ff < LW'(FRAME_DEPTH)) begin
                     for (int i = 0; i < FIELD_BYTES; i++) begin
                        if (len_ff == LW'(i)) begin
                           frame_in[i] = item.data;
                        end else if (len_ff == '0) begin
                           frame_in[i] = 8'd0;
                        end
                     end
                     len_in = len_ff + 1'b1;
                  end
                  state_in = (item.kind == KIND_EOF) ? ST_CONV : ST_SEND;
               end
            end
         end
         ST_CONV: begin
            lin_neg_in = lin_q[32];
            lin_mag_in = lin_q[31:0];
            ang_neg_in = ang_q[32];
            ang_mag_in = ang_q[31:0];
            ms_in      = to_ms({frame_ff[9], frame_ff[8], frame_ff[7], frame_ff[6]});
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = $signed({1'b0, lin_mag_ff}) * diff;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (frame_ff[0] == SYNC_BYTE) begin
               if (frame_ff[1] == ID_MOVE && !follow_ff) begin
                  move_pwm_in = (frame_ff[2] == 8'd0) ? 8'd0 : frame_ff[5];
                  rotate_in   = (frame_ff[2] == 8'd1);
                  duration_in = ms_ff;
                  dir_in      = (frame_ff[4] != 8'd0);
                  move_el_in  = 32'd0;
               end else if (frame_ff[1] == ID_VEL) begin
                  if (follow_ff) begin
                     // velocity command
                     if (lin_mag_ff > ldb) begin
                        left_in  = auto_pwm;
                        right_in = auto_pwm;
                        dir_in   = new_dir;
                        if (ang_pos) begin
                           if (!new_dir) left_in = 8'd0; else right_in = 8'd0;
                        end
                        if (ang_negv) begin
                           if (!new_dir) right_in = 8'd0; else left_in = 8'd0;
                        end
                     end else if (ang_mag_ff <= adb) begin
                        left_in  = 8'd0;
                        right_in = 8'd0;
                     end else begin
                        dir_in = 1'b0;
                        if (!ang_neg_ff) begin
                           right_in = cfg.spin_pwm;
                           left_in  = 8'd0;
                        end else begin
                           right_in = 8'd0;
                           left_in  = cfg.spin_pwm;
                        end
                     end
                     stream_el_in = 32'd0;
                  end
               end else if (frame_ff[1] == ID_FOLLOW && len_ff == LW'(FOLLOW_LEN)) begin
                  follow_in = (frame_ff[2] != 8'd0);
                  if (frame_ff[2] == 8'd0) begin
                     duration_in = 32'd0;
                     left_in     = 8'd0;
                     right_in    = 8'd0;
                     move_pwm_in = 8'd0;
                  end
               end
            end
            len_in   = '0;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            // move end check, then build the result word
            if (!follow_ff && move_el_ff >= duration_ff) pwm_eff = 8'd0;
            move_pwm_in = pwm_eff;
            if (follow_ff) begin
               dl = !dir_ff;
               if (stream_el_ff >= {16'd0, cfg.stream_timeout_ms}) begin
                  sr = 8'd0;
                  sl = 8'd0;
               end else begin
                  sr = right_ff;
                  sl = left_ff;
               end
            end else begin
               dl = rotate_ff ? dir_ff : !dir_ff;
               sr = pwm_eff;
               sl = pwm_eff;
            end
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, follow_ff, sl, sr, dl, dir_ff};
               state_in     = ST_FETCH;
            end
         end
         default: begin
            state_in = ST_FETCH;
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FETCH;
         len_ff       <= '0;
         follow_ff    <= 1'b0;
         rotate_ff    <= 1'b0;
         dir_ff       <= 1'b0;
         move_pwm_ff  <= 8'd0;
         duration_ff  <= 32'd0;
         move_el_ff   <= 32'd0;
         stream_el_ff <= 32'd0;
         left_ff      <= 8'd0;
         right_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         follow_ff    <= follow_in;
         rotate_ff    <= rotate_in;
         dir_ff       <= dir_in;
         move_pwm_ff  <= move_pwm_in;
         duration_ff  <= duration_in;
         move_el_ff   <= move_el_in;
         stream_el_ff <= stream_el_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      frame_ff    <= frame_in;
      lin_mag_ff  <= lin_mag_in;
      lin_neg_ff  <= lin_neg_in;
      ang_mag_ff  <= ang_mag_in;
      ang_neg_ff  <= ang_neg_in;
      ms_ff       <= ms_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> src/serial_drive_command_controller.sv
// Channel | Direction | Signals                      | Contents
// req     | in        | req_tvalid/tready/tdata/tuser | received byte or ms tick
// rsp     | out       | rsp_tvalid/tready/tdata       | motor directions, speeds, mode
// csr     | in        | csr_valid/ready/index/data    | register writes
//
// In the back end a tick or a plain byte goes from fetch straight to send; a
// newline byte goes through float convert, multiply, decode and send. The
// queue holds QUEUE_DEPTH words. Reset is synchronous; the frame byte store
// is not reset and is cleared at the start of each frame. rsp stalls hold the
// back end; req stays open until the queue is full.
module serial_drive_command_controller #(
   parameter int FRAME_DEPTH = 32,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] dir_right, [1] dir_left, [9:2] speed_right, [17:10] speed_left,
   // [18] follow_mode, [23:19] zero
   output logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import scdc_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   item_type item;
   logic     item_valid, item_pop;

   assign csr_ready = 1'b1;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MIN_AUTO_PWM:     cfg_in.min_auto_pwm      = csr_data[7:0];
            REG_MAX_AUTO_PWM:     cfg_in.max_auto_pwm      = csr_data[7:0];
            REG_STREAM_TIMEOUT:   cfg_in.stream_timeout_ms = csr_data;
            REG_SPIN_PWM:         cfg_in.spin_pwm          = csr_data[7:0];
            REG_LINEAR_DEADBAND:  cfg_in.linear_deadband   = csr_data;
            REG_ANGULAR_DEADBAND: cfg_in.angular_deadband  = csr_data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_auto_pwm      <= RST_MIN_AUTO_PWM;
         cfg_ff.max_auto_pwm      <= RST_MAX_AUTO_PWM;
         cfg_ff.stream_timeout_ms <= RST_STREAM_TIMEOUT;
         cfg_ff.spin_pwm          <= RST_SPIN_PWM;
         cfg_ff.linear_deadband   <= RST_LINEAR_DEADBAND;
         cfg_ff.angular_deadband  <= RST_ANGULAR_DEADBAND;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   scdc_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop)
   );

   scdc_back #(
      .FRAME_DEPTH (FRAME_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> src/scdc_checker.sv
module scdc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // nothing offered right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a stalled word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed under stall");

   // follow mode drives the motors in opposite senses
   a_follow_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[18] |-> rsp_tdata[1] != rsp_tdata[0])
      else $error("follow mode direction bits not complementary");

   // timed moves drive both wheels at one speed
   a_move_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[18] |-> rsp_tdata[9:2] == rsp_tdata[17:10])
      else $error("move speeds differ");

   // pad bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:19] == 5'd0)
      else $error("rsp pad bits set");

endmodule

bind serial_drive_command_controller scdc_checker u_checker (.*);
